### design/assert_macros.svh
// Assertion macros used by the checker file of the PPM frame decoder.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ppmfd_pkg.sv
// Package of the PPM frame decoder: reset values, register indexes,
// microcode word types and the control ROM. Depends on nothing.
`timescale 1ns / 1ps

package ppmfd_pkg;

  localparam int NUM_CHANNELS_DEFAULT = 8;

  localparam logic [31:0] CLOCK_HZ_RESET  = 32'd80000000;
  localparam logic [15:0] SYNC_US_RESET   = 16'd2700;
  localparam logic [31:0] TIMEOUT_RESET   = 32'd7999999;
  localparam logic [31:0] US_PER_SECOND   = 32'd1000000;
  localparam logic [15:0] WIDTH_MAX       = 16'hFFFF;

  // Configuration register indexes
  localparam logic [1:0] REG_CLOCK_HZ = 2'd0;
  localparam logic [1:0] REG_SYNC_US  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Program addresses
  localparam step_t S_WAIT     = 4'd0;
  localparam step_t S_CHK_TICK = 4'd1;
  localparam step_t S_CHK_FALL = 4'd2;
  localparam step_t S_CHK_DIFF = 4'd3;
  localparam step_t S_DIV1     = 4'd4;
  localparam step_t S_DIV1_W   = 4'd5;
  localparam step_t S_DIV2     = 4'd6;
  localparam step_t S_DIV2_W   = 4'd7;
  localparam step_t S_CLASSIFY = 4'd8;
  localparam step_t S_STORE    = 4'd9;
  localparam step_t S_SAT      = 4'd10;
  localparam step_t S_PREV     = 4'd11;
  localparam step_t S_SYNC     = 4'd12;
  localparam step_t S_TICK     = 4'd13;
  localparam step_t S_EMIT     = 4'd14;
  localparam step_t S_EMIT_RET = 4'd15;

  typedef enum logic [3:0] {
    C_NONE, C_ALWAYS, C_NO_ACCEPT, C_TICK, C_NOT_FALL,
    C_DIFF_BAD, C_DIV_BUSY, C_WIDE, C_OUT_FREE
  } cond_t;

  typedef enum logic [3:0] {
    A_NOP, A_LATCH, A_WIDTH, A_STORE, A_SAT, A_SYNC, A_PREV, A_TICK, A_EMIT
  } act_t;

  typedef enum logic {
    DIV_CLOCK,  // clock_hz / diff
    DIV_SCALE   // 1000000 / previous quotient
  } div_sel_t;

  typedef struct packed {
    logic     ready;
    logic     div_start;
    div_sel_t div_sel;
    act_t     act;
    cond_t    cond;
    step_t    target;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic is_tick;
    logic not_fall;
    logic diff_bad;
    logic div_busy;
    logic wide;
    logic out_free;
  } status_t;

  function automatic ucode_t mk(logic rdy, logic ds, div_sel_t sel, act_t a,
                                cond_t c, step_t t);
    ucode_t w;
    w.ready     = rdy;
    w.div_start = ds;
    w.div_sel   = sel;
    w.act       = a;
    w.cond      = c;
    w.target    = t;
    return w;
  endfunction

  // Control program: branch to target when the condition holds, else fall through.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      S_WAIT:     w = mk(1'b1, 1'b0, DIV_CLOCK, A_LATCH, C_NO_ACCEPT, S_WAIT);
      S_CHK_TICK: w = mk(1'b0, 1'b0, DIV_CLOCK, A_NOP,   C_TICK,      S_TICK);
      S_CHK_FALL: w = mk(1'b0, 1'b0, DIV_CLOCK, A_NOP,   C_NOT_FALL,  S_PREV);
      S_CHK_DIFF: w = mk(1'b0, 1'b0, DIV_CLOCK, A_NOP,   C_DIFF_BAD,  S_SAT);
      S_DIV1:     w = mk(1'b0, 1'b1, DIV_CLOCK, A_NOP,   C_NONE,      S_WAIT);
      S_DIV1_W:   w = mk(1'b0, 1'b0, DIV_CLOCK, A_NOP,   C_DIV_BUSY,  S_DIV1_W);
      S_DIV2:     w = mk(1'b0, 1'b1, DIV_SCALE, A_NOP,   C_NONE,      S_WAIT);
      S_DIV2_W:   w = mk(1'b0, 1'b0, DIV_CLOCK, A_NOP,   C_DIV_BUSY,  S_DIV2_W);
      S_CLASSIFY: w = mk(1'b0, 1'b0, DIV_CLOCK, A_WIDTH, C_WIDE,      S_SYNC);
      S_STORE:    w = mk(1'b0, 1'b0, DIV_CLOCK, A_STORE, C_ALWAYS,    S_PREV);
      S_SAT:      w = mk(1'b0, 1'b0, DIV_CLOCK, A_SAT,   C_ALWAYS,    S_SYNC);
      S_PREV:     w = mk(1'b0, 1'b0, DIV_CLOCK, A_PREV,  C_ALWAYS,    S_EMIT);
      S_SYNC:     w = mk(1'b0, 1'b0, DIV_CLOCK, A_SYNC,  C_ALWAYS,    S_PREV);
      S_TICK:     w = mk(1'b0, 1'b0, DIV_CLOCK, A_TICK,  C_ALWAYS,    S_EMIT);
      S_EMIT:     w = mk(1'b0, 1'b0, DIV_CLOCK, A_EMIT,  C_OUT_FREE,  S_WAIT);
      S_EMIT_RET: w = mk(1'b0, 1'b0, DIV_CLOCK, A_NOP,   C_ALWAYS,    S_EMIT);
      default:    w = mk(1'b0, 1'b0, DIV_CLOCK, A_NOP,   C_ALWAYS,    S_WAIT);
    endcase
    return w;
  endfunction

endpackage

### design/ppm_frame_decoder.sv
// PPM frame decoder: one item at a time, one result per item.
// A tick counts down the timeout; an edge that is not falling records its stamp;
// a zero or oversized gap saturates the width and marks sync; a falling edge runs
// two serial divides. A stalled result holds the next item.
// Reset (rst, synchronous): widths and slot cleared, timeout loaded, registers to
// their defaults; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps

module ppm_frame_decoder
  import ppmfd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] capture_time,
  input  logic        pin_level,
  input  logic [15:0] elapsed_ticks,
  input  logic [2:0]  read_slot,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_valid,
  output logic        sync_seen,
  output logic        channel_written,
  output logic [2:0]  written_slot,
  output logic [15:0] pulse_width_us,
  output logic [15:0] read_width,
  output logic        timed_out
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  // Configuration registers
  logic [31:0] clock_hz;
  logic [15:0] sync_threshold_us;
  logic [31:0] timeout_reload;

  // Decoder state
  logic [15:0]      channel_widths [NUM_CHANNELS];
  logic [CNT_W-1:0] channel_slot;
  logic [31:0]      previous_stamp;
  logic             previous_level;
  logic             valid_flag;
  logic [31:0]      timeout_count;

  // Latched item
  logic        it_opcode;
  logic [31:0] it_stamp;
  logic        it_level;
  logic [15:0] it_ticks;
  logic [2:0]  it_rslot;

  // Result being built
  logic        res_sync;
  logic        res_written;
  logic [2:0]  res_wslot;
  logic [15:0] res_width;
  logic        res_expired;

  ucode_t  ctrl;
  status_t status;

  logic        accept;
  logic        out_free;
  logic [31:0] diff;
  logic        div_busy;
  logic [31:0] div_quot;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic [15:0] width_sat;
  logic        all_nonzero;
  logic [4:0]  slot_ext;
  logic [4:0]  rd_ext;
  logic [15:0] rd_width;
  logic        slot_free;

  assign in_ready = ctrl.ready;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Time since the previous edge, modulo 2^32
  assign diff = it_stamp - previous_stamp;

  // Saturate the scaled width to 16 bits
  assign width_sat = (|div_quot[31:16]) ? WIDTH_MAX : div_quot[15:0];

  assign slot_ext  = 5'(channel_slot);
  assign slot_free = slot_ext < 5'(NUM_CHANNELS);
  assign rd_ext    = {2'b00, it_rslot};

  always_comb begin
    all_nonzero = 1'b1;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (channel_widths[i] == 16'd0) begin
        all_nonzero = 1'b0;
      end
    end
  end

  // Out-of-range read slots return zero
  assign rd_width = (rd_ext < 5'(NUM_CHANNELS)) ? channel_widths[rd_ext[IDX_W-1:0]] : 16'd0;

  always_comb begin
    status.accept   = accept;
    status.is_tick  = it_opcode;
    status.not_fall = !(previous_level && !it_level);
    status.diff_bad = (diff == 32'd0) || (diff > clock_hz);
    status.div_busy = div_busy;
    status.wide     = width_sat > sync_threshold_us;
    status.out_free = out_free;
  end

  // First divide: clock_hz / diff; second: 1000000 / first quotient
  assign div_dividend = (ctrl.div_sel == DIV_SCALE) ? US_PER_SECOND : clock_hz;
  assign div_divisor  = (ctrl.div_sel == DIV_SCALE) ? div_quot : diff;

  ppmfd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  ppmfd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // Configuration: a write lands at once; keep writes to idle stretches;
  // index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz          <= CLOCK_HZ_RESET;
      sync_threshold_us <= SYNC_US_RESET;
      timeout_reload    <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLOCK_HZ: clock_hz          <= cfg_data;
        REG_SYNC_US:  sync_threshold_us <= cfg_data[15:0];
        REG_TIMEOUT:  timeout_reload    <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Datapath driven by the current control word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_widths[i] <= 16'd0;
      end
      channel_slot   <= '0;
      previous_stamp <= 32'd0;
      previous_level <= 1'b0;
      valid_flag     <= 1'b0;
      timeout_count  <= TIMEOUT_RESET;
      out_valid      <= 1'b0;
    end else begin
      // load a new result when free, else drop the held one once it transfers
      if (ctrl.act == A_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (ctrl.act)
        A_LATCH: begin
          if (accept) begin
            it_opcode   <= opcode;
            it_stamp    <= capture_time;
            it_level    <= pin_level;
            it_ticks    <= elapsed_ticks;
            it_rslot    <= read_slot;
            res_sync    <= 1'b0;
            res_written <= 1'b0;
            res_wslot   <= 3'd0;
            res_width   <= 16'd0;
            res_expired <= 1'b0;
          end
        end
        A_WIDTH: res_width <= width_sat;
        A_SAT:   res_width <= WIDTH_MAX;
        A_STORE: begin
          // a full frame drops further widths
          if (slot_free) begin
            channel_widths[slot_ext[IDX_W-1:0]] <= res_width;
            res_written  <= 1'b1;
            res_wslot    <= slot_ext[2:0];
            channel_slot <= channel_slot + CNT_W'(1);
          end
        end
        A_SYNC: begin
          res_sync     <= 1'b1;
          channel_slot <= '0;
          valid_flag   <= all_nonzero;
          if (all_nonzero) begin
            timeout_count <= timeout_reload;
          end
        end
        A_PREV: begin
          previous_stamp <= it_stamp;
          previous_level <= it_level;
        end
        A_TICK: begin
          // expiry discards leftover ticks and reloads
          if ({16'd0, it_ticks} > timeout_count) begin
            res_expired   <= 1'b1;
            valid_flag    <= 1'b0;
            timeout_count <= timeout_reload;
          end else begin
            timeout_count <= timeout_count - {16'd0, it_ticks};
          end
        end
        A_EMIT: begin
          // hold until the output register is free
          if (out_free) begin
            frame_valid     <= valid_flag;
            sync_seen       <= res_sync;
            channel_written <= res_written;
            written_slot    <= res_wslot;
            pulse_width_us  <= res_width;
            read_width      <= rd_width;
            timed_out       <= res_expired;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### design/ppmfd_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing beyond the clock and reset.
`timescale 1ns / 1ps

module ppmfd_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [4:0]  count;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted  = {rem, quo[31]};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 5'd31;
      rem   <= '0;
      quo   <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      // trial[32] clear means the shifted remainder covers the divisor
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[30:0], 1'b0};
      end
      if (count == 5'd0) begin
        busy <= 1'b0;
      end
      count <= count - 5'd1;
    end
  end

endmodule

### design/ppmfd_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and branch logic.
// Depends on ppmfd_pkg for the control word, status and program.
`timescale 1ns / 1ps

module ppmfd_sequencer
  import ppmfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ucode_t  ctrl
);

  step_t step;
  step_t step_next;
  logic  take;

  assign ctrl = ucode_rom(step);

  always_comb begin
    case (ctrl.cond)
      C_NONE:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_ACCEPT: take = !status.accept;
      C_TICK:      take = status.is_tick;
      C_NOT_FALL:  take = status.not_fall;
      C_DIFF_BAD:  take = status.diff_bad;
      C_DIV_BUSY:  take = status.div_busy;
      C_WIDE:      take = status.wide;
      C_OUT_FREE:  take = status.out_free;
      default:     take = 1'b1;
    endcase
    step_next = take ? ctrl.target : step + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

### design/ppmfd_checker.sv
// Port-level checker for the PPM frame decoder, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppmfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        frame_valid,
  input logic        sync_seen,
  input logic        channel_written,
  input logic [2:0]  written_slot,
  input logic        timed_out
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ASSERT_IMPLIES(a_sync_xor_write, clk, rst, out_valid, !(sync_seen && channel_written), "sync edge also stored a width")
  `ASSERT_IMPLIES(a_slot_zero, clk, rst, out_valid && !channel_written, written_slot == 3'd0, "slot reported without a store")
  `ASSERT_IMPLIES(a_timeout_clean, clk, rst, out_valid && timed_out, !frame_valid && !sync_seen && !channel_written, "expiry left frame state set")

endmodule

bind ppm_frame_decoder ppmfd_checker u_ppmfd_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .frame_valid     (frame_valid),
  .sync_seen       (sync_seen),
  .channel_written (channel_written),
  .written_slot    (written_slot),
  .timed_out       (timed_out)
);
